// ===== hw/rtl/phd_pkg.sv =====
package phd_pkg;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // tag byte classes, taken from the top two bits
    localparam logic [1:0] TAG_OLD = 2'b10;
    localparam logic [1:0] TAG_NEW = 2'b11;

    // old-format length types
    localparam logic [1:0] OLD_LEN_1   = 2'd0;
    localparam logic [1:0] OLD_LEN_2   = 2'd1;
    localparam logic [1:0] OLD_LEN_4   = 2'd2;
    localparam logic [1:0] OLD_LEN_BAD = 2'd3;

    // new-format length byte limits
    localparam logic [7:0]  NEW_TWO_BYTE = 8'hc0;
    localparam logic [7:0]  NEW_BAD      = 8'he0;
    localparam logic [7:0]  NEW_HI_MASK  = 8'h3f;
    localparam logic [31:0] NEW_OFFSET   = 32'd192;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  tag_byte;
        logic [31:0] packet_length;
        logic [31:0] header_position;
    } out_t;

endpackage

// ===== hw/rtl/packet_header_decoder.sv =====
// Packet header decoder: parses tagged packet headers from a byte stream.
// Byte channel (byte_valid, byte_stall, byte_data): one stream byte per
// transfer, or an end-of-data mark when byte_data.end_of_data is set.
// Result channel (result_valid, result_stall, result_data): one transfer
// per finished header, rejected header, truncated header or end mark;
// bytes inside a header produce no result.
// Throughput is one byte per cycle while result_stall does not hold the
// output register: each byte waits in the input register, the tag, length
// and offset state is updated in a single pass, then the result is held in
// the output register.
// When the receiver stalls, the output register holds its result and the
// input register keeps its byte; byte_stall rises only while both are full
// and result_stall is high.
// Reset clears the valid flags of both registers, returns the parser to
// waiting for a tag byte and clears the stream offset to zero.
module packet_header_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  phd_pkg::in_t  byte_data,
    output logic          result_valid,
    input  logic          result_stall,
    output phd_pkg::out_t result_data
);

    logic          s1_valid_reg, s1_valid_next;
    phd_pkg::in_t  s1_item_reg;
    logic          out_valid_reg, out_valid_next;
    phd_pkg::out_t out_data_reg;

    logic          accept;
    logic          advance;
    logic          fire;
    phd_pkg::out_t result;

    // handshake control
    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = s1_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = fire;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    phd_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .fire   (fire),
        .result (result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= byte_data;
        if (advance && fire)
            out_data_reg <= result;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

// ===== hw/rtl/phd_parse.sv =====
module phd_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  phd_pkg::in_t  item,
    output logic          fire,
    output phd_pkg::out_t result
);

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_OLD  = 4'b0010,
        PH_NEW1 = 4'b0100,
        PH_NEW2 = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_tag_reg, held_tag_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  left_reg, left_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] tag_offset_reg, tag_offset_next;

    logic [7:0]  b;
    logic [2:0]  left_dec;
    logic [31:0] acc_shift;

    assign b         = item.data_byte;
    assign left_dec  = left_reg - 3'd1;
    assign acc_shift = {acc_reg[23:0], 8'h00};

    // header parse for one byte or end mark
    always_comb
    begin
        phase_next      = phase_reg;
        held_tag_next   = held_tag_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        offset_next     = offset_reg;
        tag_offset_next = tag_offset_reg;
        fire            = 1'b0;
        result          = '0;

        if (item.end_of_data)
        begin
            fire = 1'b1;
            if (phase_reg == PH_WAIT)
            begin
                result.status          = phd_pkg::ST_END;
                result.header_position = offset_reg;
            end
            else
            begin
                result.status          = phd_pkg::ST_TRUNC;
                result.header_position = tag_offset_reg;
            end
        end
        else
        begin
            offset_next = offset_reg + 32'd1;
            unique case (phase_reg)
                PH_WAIT:
                begin
                    held_tag_next   = b;
                    tag_offset_next = offset_reg;
                    acc_next        = '0;
                    if (b[7:6] == phd_pkg::TAG_OLD)
                    begin
                        unique case (b[1:0])
                            phd_pkg::OLD_LEN_1:   left_next = 3'd1;
                            phd_pkg::OLD_LEN_2:   left_next = 3'd2;
                            phd_pkg::OLD_LEN_4:   left_next = 3'd4;
                            phd_pkg::OLD_LEN_BAD: left_next = 3'd0;
                        endcase
                        if (b[1:0] == phd_pkg::OLD_LEN_BAD)
                        begin
                            fire                   = 1'b1;
                            result.status          = phd_pkg::ST_BAD;
                            result.header_position = offset_reg;
                        end
                        else
                        begin
                            phase_next = PH_OLD;
                        end
                    end
                    else if (b[7:6] == phd_pkg::TAG_NEW)
                    begin
                        phase_next = PH_NEW1;
                    end
                    else
                    begin
                        fire                   = 1'b1;
                        result.status          = phd_pkg::ST_BAD;
                        result.header_position = offset_reg;
                    end
                end
                PH_OLD:
                begin
                    acc_next  = acc_shift | {24'd0, b};
                    left_next = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        fire                   = 1'b1;
                        result.status          = phd_pkg::ST_DONE;
                        result.tag_byte        = held_tag_reg;
                        result.packet_length   = acc_shift | {24'd0, b};
                        result.header_position = tag_offset_reg;
                    end
                end
                PH_NEW1:
                begin
                    if (b < phd_pkg::NEW_TWO_BYTE)
                    begin
                        fire                   = 1'b1;
                        result.status          = phd_pkg::ST_DONE;
                        result.tag_byte        = held_tag_reg;
                        result.packet_length   = {24'd0, b};
                        result.header_position = tag_offset_reg;
                    end
                    else if (b < phd_pkg::NEW_BAD)
                    begin
                        acc_next   = {24'd0, b & phd_pkg::NEW_HI_MASK};
                        phase_next = PH_NEW2;
                    end
                    else
                    begin
                        fire                   = 1'b1;
                        result.status          = phd_pkg::ST_BAD;
                        result.header_position = tag_offset_reg;
                    end
                end
                PH_NEW2:
                begin
                    acc_next               = acc_shift + {24'd0, b} + phd_pkg::NEW_OFFSET;
                    fire                   = 1'b1;
                    result.status          = phd_pkg::ST_DONE;
                    result.tag_byte        = held_tag_reg;
                    result.packet_length   = acc_shift + {24'd0, b} + phd_pkg::NEW_OFFSET;
                    result.header_position = tag_offset_reg;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end

        // any result sends the parser back to waiting for a tag
        if (fire)
        begin
            phase_next = PH_WAIT;
            left_next  = 3'd0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            held_tag_reg   <= '0;
            acc_reg        <= '0;
            left_reg       <= '0;
            offset_reg     <= '0;
            tag_offset_reg <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            held_tag_reg   <= held_tag_next;
            acc_reg        <= acc_next;
            left_reg       <= left_next;
            offset_reg     <= offset_next;
            tag_offset_reg <= tag_offset_next;
        end
    end

endmodule

// ===== tb/phd_checker.sv =====
`timescale 1ns / 100ps

module packet_header_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    input  logic          byte_stall,
    input  phd_pkg::in_t  byte_data,
    input  logic          result_valid,
    input  logic          result_stall,
    input  phd_pkg::out_t result_data,
    output int            fail_count,
    output int            pending
);
    import phd_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        WAIT_TAG,
        OLD_LENGTH,
        NEW_FIRST,
        NEW_SECOND
    } parse_phase_t;

    // parser state mirrored from the stream
    parse_phase_t phase;
    logic [7:0]   held_tag;
    logic [31:0]  len_acc;
    logic [2:0]   len_bytes_left;
    logic [31:0]  stream_offset;
    logic [31:0]  tag_offset;

    out_t expected_hdrs[$];

    // advance the parser by one byte transfer, queue a header result if one ends here
    task automatic decode_byte(input in_t item);
        logic [7:0]  b;
        logic [31:0] pos;
        out_t        hdr;
        bit          emit;
        hdr  = '0;
        emit = 1'b0;
        b    = item.data_byte;
        if (item.end_of_data)
        begin
            emit = 1'b1;
            if (phase == WAIT_TAG)
            begin
                hdr.status          = ST_END;
                hdr.header_position = stream_offset;
            end
            else
            begin
                hdr.status          = ST_TRUNC;
                hdr.header_position = tag_offset;
            end
        end
        else
        begin
            pos           = stream_offset;
            stream_offset = stream_offset + 32'd1;
            case (phase)
                WAIT_TAG:
                begin
                    held_tag   = b;
                    tag_offset = pos;
                    len_acc    = '0;
                    if (b[7:6] == TAG_OLD)
                    begin
                        if (b[1:0] == OLD_LEN_BAD)
                        begin
                            emit                = 1'b1;
                            hdr.status          = ST_BAD;
                            hdr.header_position = pos;
                        end
                        else
                        begin
                            len_bytes_left = (b[1:0] == OLD_LEN_4) ? 3'd4
                                                                   : 3'(b[1:0]) + 3'd1;
                            phase = OLD_LENGTH;
                        end
                    end
                    else if (b[7:6] == TAG_NEW)
                    begin
                        phase = NEW_FIRST;
                    end
                    else
                    begin
                        emit                = 1'b1;
                        hdr.status          = ST_BAD;
                        hdr.header_position = pos;
                    end
                end
                OLD_LENGTH:
                begin
                    len_acc        = {len_acc[23:0], b};
                    len_bytes_left = len_bytes_left - 3'd1;
                    if (len_bytes_left == 3'd0)
                    begin
                        emit                = 1'b1;
                        hdr.status          = ST_DONE;
                        hdr.tag_byte        = held_tag;
                        hdr.packet_length   = len_acc;
                        hdr.header_position = tag_offset;
                    end
                end
                NEW_FIRST:
                begin
                    if (b < NEW_TWO_BYTE)
                    begin
                        emit                = 1'b1;
                        hdr.status          = ST_DONE;
                        hdr.tag_byte        = held_tag;
                        hdr.packet_length   = 32'(b);
                        hdr.header_position = tag_offset;
                    end
                    else if (b < NEW_BAD)
                    begin
                        len_acc = 32'(b & NEW_HI_MASK);
                        phase   = NEW_SECOND;
                    end
                    else
                    begin
                        emit                = 1'b1;
                        hdr.status          = ST_BAD;
                        hdr.header_position = tag_offset;
                    end
                end
                default:
                begin
                    len_acc             = (len_acc << 8) + 32'(b) + NEW_OFFSET;
                    emit                = 1'b1;
                    hdr.status          = ST_DONE;
                    hdr.tag_byte        = held_tag;
                    hdr.packet_length   = len_acc;
                    hdr.header_position = tag_offset;
                end
            endcase
        end
        // every result sends the parser back to waiting for a tag
        if (emit)
        begin
            phase          = WAIT_TAG;
            len_bytes_left = '0;
            expected_hdrs.push_back(hdr);
        end
    endtask

    // compare one result transfer against the oldest queued header
    task automatic check_result(input out_t got);
        out_t want;
        if (expected_hdrs.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: unexpected result: status %0d tag %02h len %0d pos %0d",
                         $realtime, got.status, got.tag_byte, got.packet_length,
                         got.header_position);
        end
        else
        begin
            want = expected_hdrs.pop_front();
            if (got.status !== want.status || got.tag_byte !== want.tag_byte ||
                got.packet_length !== want.packet_length ||
                got.header_position !== want.header_position)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected: status %0d tag %02h len %0d pos %0d",
                             want.status, want.tag_byte, want.packet_length,
                             want.header_position);
                    $display("  actual:   status %0d tag %02h len %0d pos %0d",
                             got.status, got.tag_byte, got.packet_length,
                             got.header_position);
                end
            end
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase          = WAIT_TAG;
            held_tag       = '0;
            len_acc        = '0;
            len_bytes_left = '0;
            stream_offset  = '0;
            tag_offset     = '0;
            expected_hdrs.delete();
            pending        = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_data);
            if (byte_valid && !byte_stall)
                decode_byte(byte_data);
            pending = expected_hdrs.size();
        end
    end

endmodule

// ===== tb/tb_packet_header_decoder.sv =====
`timescale 1ns / 100ps

module tb_packet_header_decoder;
    import phd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic byte_valid;
    logic byte_stall;
    in_t  byte_data;
    logic result_valid;
    logic result_stall;
    out_t result_data;

    int fail_count;
    int pending;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req_cnt;
    int hold_ack_cnt;
    int hold_left;
    int idle_cycles = 0;

    packet_header_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    packet_header_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: random stall, plus one long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        hold_ack_cnt = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req_cnt != hold_ack_cnt)
            begin
                hold_ack_cnt = hold_req_cnt;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one byte or end mark and hold it until the transfer
    task automatic send_item(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid            <= 1'b1;
        byte_data.data_byte   <= b;
        byte_data.end_of_data <= eod;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // old-format header, optionally cut short by an end mark
    task automatic send_old_header(input bit cut);
        logic [1:0] ltype;
        int         n;
        int         k;
        ltype = 2'($urandom_range(OLD_LEN_4, OLD_LEN_1));
        n     = (ltype == OLD_LEN_4) ? 4 : int'(ltype) + 1;
        k     = cut ? $urandom_range(n - 1) : n;
        send_item({TAG_OLD, 4'($urandom), ltype}, 1'b0);
        repeat (k)
            send_item(8'($urandom), 1'b0);
        if (cut)
            send_item(8'($urandom), 1'b1);
    endtask

    // new-format header with one or two length bytes, optionally cut short
    task automatic send_new_header(input bit cut);
        logic [7:0] first;
        bit         two;
        two   = $urandom_range(1);
        first = two ? NEW_TWO_BYTE + 8'($urandom_range(NEW_BAD - NEW_TWO_BYTE - 1))
                    : 8'($urandom_range(NEW_TWO_BYTE - 1));
        send_item({TAG_NEW, 6'($urandom)}, 1'b0);
        if (!cut || two)
            send_item(first, 1'b0);
        if (cut)
            send_item(8'($urandom), 1'b1);
        else if (two)
            send_item(8'($urandom), 1'b0);
    endtask

    // mostly well-formed headers with random content, some broken ones and noise
    task automatic run_random(input int stop_at);
        int pick;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_old_header(1'b0);
            else if (pick < 72)
                send_new_header(1'b0);
            else if (pick < 80)
            begin
                if (pick[0])
                    send_old_header(1'b1);
                else
                    send_new_header(1'b1);
            end
            else if (pick < 86)
            begin
                send_item({TAG_NEW, 6'($urandom)}, 1'b0);
                send_item(NEW_BAD + 8'($urandom_range(8'hff - NEW_BAD)), 1'b0);
            end
            else if (pick < 90)
            begin
                if (pick[0])
                    send_item({1'b0, 7'($urandom)}, 1'b0);
                else
                    send_item({TAG_OLD, 4'($urandom), OLD_LEN_BAD}, 1'b0);
            end
            else if (pick < 94)
                send_item(8'($urandom), 1'b1);
            else
                send_item(8'($urandom), 1'b0);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        byte_data     = '0;
        items_sent    = 0;
        hold_req_cnt  = 0;
        send_idle_pct = 12;
        recv_idle_pct = 87;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // clean end while waiting for a tag
        send_item(8'h5a, 1'b1);
        // old format with one, two and four length bytes
        send_item(8'h80, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h85, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'hbe, 1'b0);
        repeat (4) send_item(8'hff, 1'b0);
        // old length type three, then tags with the top bit clear
        send_item(8'h83, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h7f, 1'b0);
        // new format, largest one-byte and two-byte lengths
        send_item(8'hff, 1'b0);
        send_item(8'hbf, 1'b0);
        send_item(8'hc0, 1'b0);
        send_item(8'hdf, 1'b0);
        send_item(8'hff, 1'b0);
        // new format first length byte out of range
        send_item(8'hd1, 1'b0);
        send_item(8'he0, 1'b0);
        // end of data inside new and old headers
        send_item(8'hc5, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h86, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hff, 1'b1);

        run_random(150);
        send_idle_pct = 87;
        recv_idle_pct = 12;
        run_random(275);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_cnt++;
        run_random(ITEM_TARGET);
        byte_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
